[rtl/bfa_pkg.sv]
// Shared types, widths and codes for the best-fit block allocator.
package bfa_pkg;

  localparam int MaxBlocks = 32;
  localparam int SizeBits  = 16;
  localparam int IdxW      = $clog2(MaxBlocks);
  localparam int CntW      = $clog2(MaxBlocks + 1);
  localparam int FreeW     = SizeBits + CntW;
  localparam int SumW      = 32;
  localparam int ExtW      = (FreeW > SumW) ? FreeW : SumW;

  localparam logic [1:0] OpAdd   = 2'd0;
  localparam logic [1:0] OpAlloc = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  typedef enum logic [2:0] {
    StatAdded = 3'd0,
    StatFull  = 3'd1,
    StatAlloc = 3'd2,
    StatWait  = 3'd3,
    StatClear = 3'd4
  } stat_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

  typedef struct packed {
    logic [1:0]          operation;
    logic [SizeBits-1:0] size;
  } req_t;

  typedef struct packed {
    stat_e               status;
    logic [IdxW-1:0]     block_index;
    logic [SizeBits-1:0] leftover;
    logic [SumW-1:0]     total_internal_frag;
    logic [SumW-1:0]     external_frag;
  } res_t;

  typedef struct packed {
    logic                we;
    logic [IdxW-1:0]     waddr;
    logic [SizeBits-1:0] wdata;
    logic [IdxW-1:0]     raddr;
    logic                set_used;
    logic [IdxW-1:0]     set_idx;
    logic                clr_all;
  } tbl_ctl_t;

endpackage

[rtl/bfa_table.sv]
// Block size memory and per-block used flags, one registered read port.
module bfa_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bfa_pkg::tbl_ctl_t              ctl_i,
  output logic [bfa_pkg::SizeBits-1:0]   rd_size_o,
  output logic                           rd_used_o
);

  logic [bfa_pkg::SizeBits-1:0]  mem_q [bfa_pkg::MaxBlocks];
  logic [bfa_pkg::SizeBits-1:0]  rd_size_q;
  logic [bfa_pkg::MaxBlocks-1:0] used_q;
  logic                          rd_used_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[ctl_i.waddr] <= ctl_i.wdata;
    end
    rd_size_q <= mem_q[ctl_i.raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      rd_used_q <= 1'b0;
    end else begin
      rd_used_q <= used_q[ctl_i.raddr];
      if (ctl_i.clr_all) begin
        used_q <= '0;
      end else begin
        if (ctl_i.we) begin
          used_q[ctl_i.waddr] <= 1'b0;
        end
        if (ctl_i.set_used) begin
          used_q[ctl_i.set_idx] <= 1'b1;
        end
      end
    end
  end

  assign rd_size_o = rd_size_q;
  assign rd_used_o = rd_used_q;

endmodule

[rtl/best_fit_block_allocator.sv]
// Best-fit allocator top level: sequencer, shared compare unit and running sums.
//
//   channel   ports                     direction  accepted when
//   command   start_i, req_i, busy_o    in         start_i & !busy_o
//   result    res_valid_o, res_o        out        res_valid_o (one cycle)
//
// Add and clear items finish in the idle state; the result strobes on the next cycle.
// An allocate item walks the table one entry per cycle through the single
// memory read port and the shared compare unit, then passes through the
// finish state before its result strobes.
// Reset empties the table at once (used flags and count are flip-flops).
// The receiver cannot stall; busy_o drops in the cycle the result is shown.
module best_fit_block_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  bfa_pkg::req_t req_i,
  output logic          res_valid_o,
  output bfa_pkg::res_t res_o
);

  localparam int SizeBits  = bfa_pkg::SizeBits;
  localparam int IdxW      = bfa_pkg::IdxW;
  localparam int CntW      = bfa_pkg::CntW;
  localparam int FreeW     = bfa_pkg::FreeW;
  localparam int SumW      = bfa_pkg::SumW;
  localparam int ExtW      = bfa_pkg::ExtW;
  localparam int MaxBlocks = bfa_pkg::MaxBlocks;

  bfa_pkg::state_e state_q, state_d;

  logic [CntW-1:0]     count_q, count_d;
  logic [FreeW-1:0]    free_q, free_d;
  logic [SumW-1:0]     waiting_q, waiting_d;
  logic [SumW-1:0]     internal_q, internal_d;
  logic [CntW-1:0]     scan_q, scan_d;
  logic                pv_q, pv_d;
  logic                found_q, found_d;
  logic                res_valid_q, res_valid_d;

  logic [SizeBits-1:0] sz_q, sz_d;
  logic [IdxW-1:0]     pidx_q, pidx_d;
  logic [IdxW-1:0]     best_idx_q, best_idx_d;
  logic [SizeBits-1:0] best_size_q, best_size_d;
  bfa_pkg::stat_e      stat_q, stat_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [SizeBits-1:0] left_q, left_d;

  bfa_pkg::tbl_ctl_t   ctl;
  logic [SizeBits-1:0] rd_size;
  logic                rd_used;

  logic                issue;
  logic                hit;
  logic [SizeBits-1:0] left_val;
  logic [SumW:0]       int_sum;
  logic [SumW:0]       wait_sum;
  logic [ExtW-1:0]     free_ext;
  logic [ExtW-1:0]     wait_ext;
  logic [ExtW-1:0]     ext_diff;
  logic [SumW-1:0]     ext_frag;

  bfa_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .rd_size_o (rd_size),
    .rd_used_o (rd_used)
  );

  // shared compare unit: one table entry per cycle
  assign issue = (scan_q != count_q);
  assign hit   = pv_q && !rd_used && (sz_q <= rd_size) &&
                 (!found_q || (rd_size < best_size_q));

  assign left_val = best_size_q - sz_q;
  assign int_sum  = {1'b0, internal_q} + (SumW+1)'(left_val);
  assign wait_sum = {1'b0, waiting_q} + (SumW+1)'(sz_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    free_d      = free_q;
    waiting_d   = waiting_q;
    internal_d  = internal_q;
    scan_d      = scan_q;
    pv_d        = 1'b0;
    found_d     = found_q;
    res_valid_d = 1'b0;
    sz_d        = sz_q;
    pidx_d      = pidx_q;
    best_idx_d  = best_idx_q;
    best_size_d = best_size_q;
    stat_d      = stat_q;
    idx_d       = idx_q;
    left_d      = left_q;

    ctl          = '0;
    ctl.raddr    = scan_q[IdxW-1:0];
    ctl.waddr    = count_q[IdxW-1:0];
    ctl.wdata    = req_i.size;
    ctl.set_idx  = best_idx_q;

    unique case (state_q)
      bfa_pkg::StIdle: begin
        if (start_i) begin
          case (req_i.operation) inside
            bfa_pkg::OpAdd: begin
              res_valid_d = 1'b1;
              left_d      = '0;
              if (count_q == CntW'(MaxBlocks)) begin
                stat_d = bfa_pkg::StatFull;
                idx_d  = '0;
              end else begin
                ctl.we  = 1'b1;
                stat_d  = bfa_pkg::StatAdded;
                idx_d   = count_q[IdxW-1:0];
                count_d = count_q + CntW'(1);
                free_d  = free_q + FreeW'(req_i.size);
              end
            end
            bfa_pkg::OpAlloc: begin
              sz_d    = req_i.size;
              scan_d  = '0;
              found_d = 1'b0;
              state_d = bfa_pkg::StScan;
            end
            default: begin
              // clear, also taken by the unused code
              ctl.clr_all = 1'b1;
              count_d     = '0;
              free_d      = '0;
              waiting_d   = '0;
              internal_d  = '0;
              stat_d      = bfa_pkg::StatClear;
              idx_d       = '0;
              left_d      = '0;
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      bfa_pkg::StScan: begin
        pv_d   = issue;
        pidx_d = scan_q[IdxW-1:0];
        if (issue) begin
          scan_d = scan_q + CntW'(1);
        end
        if (hit) begin
          found_d     = 1'b1;
          best_idx_d  = pidx_q;
          best_size_d = rd_size;
        end
        if (!issue && !pv_q) begin
          state_d = bfa_pkg::StFinish;
        end
      end
      bfa_pkg::StFinish: begin
        res_valid_d = 1'b1;
        state_d     = bfa_pkg::StIdle;
        if (found_q) begin
          ctl.set_used = 1'b1;
          free_d       = free_q - FreeW'(best_size_q);
          internal_d   = int_sum[SumW] ? '1 : int_sum[SumW-1:0];
          stat_d       = bfa_pkg::StatAlloc;
          idx_d        = best_idx_q;
          left_d       = left_val;
        end else begin
          waiting_d = wait_sum[SumW] ? '1 : wait_sum[SumW-1:0];
          stat_d    = bfa_pkg::StatWait;
          idx_d     = '0;
          left_d    = '0;
        end
      end
      default: begin
        state_d = bfa_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfa_pkg::StIdle;
      count_q     <= '0;
      free_q      <= '0;
      waiting_q   <= '0;
      internal_q  <= '0;
      scan_q      <= '0;
      pv_q        <= 1'b0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      free_q      <= free_d;
      waiting_q   <= waiting_d;
      internal_q  <= internal_d;
      scan_q      <= scan_d;
      pv_q        <= pv_d;
      found_q     <= found_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sz_q        <= sz_d;
    pidx_q      <= pidx_d;
    best_idx_q  <= best_idx_d;
    best_size_q <= best_size_d;
    stat_q      <= stat_d;
    idx_q       <= idx_d;
    left_q      <= left_d;
  end

  // sums only move when an item finishes, so they hold through the strobe cycle
  assign free_ext = ExtW'(free_q);
  assign wait_ext = ExtW'(waiting_q);
  assign ext_diff = free_ext - wait_ext;

  always_comb begin
    if (free_ext < wait_ext) begin
      ext_frag = '0;
    end else if ((ext_diff >> SumW) != '0) begin
      ext_frag = '1;
    end else begin
      ext_frag = ext_diff[SumW-1:0];
    end
  end

  assign busy_o                    = (state_q != bfa_pkg::StIdle);
  assign res_valid_o               = res_valid_q;
  assign res_o.status              = stat_q;
  assign res_o.block_index         = idx_q;
  assign res_o.leftover            = left_q;
  assign res_o.total_internal_frag = internal_q;
  assign res_o.external_frag       = ext_frag;

endmodule

[test/tb_best_fit_block_allocator.sv]
// Self-checking testbench for the best-fit block allocator: directed cases plus random traffic.
module tb_best_fit_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxBlocks = bfa_pkg::MaxBlocks;
  localparam int SizeBits  = bfa_pkg::SizeBits;
  localparam int IdxW      = bfa_pkg::IdxW;
  localparam int SumW      = bfa_pkg::SumW;

  localparam logic [1:0] OpSpare = 2'd3;  // unused code, decodes as clear
  localparam longint unsigned Sat32 = 64'hFFFF_FFFF;
  localparam int CycleLimit = 2_000_000;
  localparam int DrainCycles = 2 * (MaxBlocks + 3) + 10;

  logic          clk_i;
  logic          rst_ni;
  logic          start_i;
  logic          busy_o;
  bfa_pkg::req_t req_i;
  logic          res_valid_o;
  bfa_pkg::res_t res_o;

  best_fit_block_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // Predicted allocator state
  logic [SizeBits-1:0] tbl_size [MaxBlocks];
  bit                  tbl_used [MaxBlocks];
  int                  tbl_count;
  longint unsigned     free_total;
  longint unsigned     wait_total;
  longint unsigned     frag_total;

  bfa_pkg::res_t pending_results[$];
  bfa_pkg::res_t want;
  int   n_items;
  int   n_errors;
  int   n_status [5];
  int   cycle_cnt;
  bit   gaps_on;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void clear_table();
    for (int i = 0; i < MaxBlocks; i++) tbl_used[i] = 1'b0;
    tbl_count  = 0;
    free_total = 0;
    wait_total = 0;
    frag_total = 0;
  endfunction

  function automatic bfa_pkg::res_t next_alloc_result(bfa_pkg::req_t item);
    bfa_pkg::res_t r;
    int   best;
    bit   found;
    r     = '0;
    found = 1'b0;
    best  = 0;
    if (item.operation[1]) begin
      clear_table();
      r.status = bfa_pkg::StatClear;
    end else if (item.operation == bfa_pkg::OpAdd) begin
      if (tbl_count >= MaxBlocks) begin
        r.status = bfa_pkg::StatFull;
      end else begin
        tbl_size[tbl_count] = item.size;
        tbl_used[tbl_count] = 1'b0;
        r.block_index = IdxW'(tbl_count);
        tbl_count++;
        free_total += item.size;
        r.status = bfa_pkg::StatAdded;
      end
    end else begin
      for (int i = 0; i < tbl_count; i++) begin
        if (!tbl_used[i] && item.size <= tbl_size[i] &&
            (!found || tbl_size[i] < tbl_size[best])) begin
          best  = i;
          found = 1'b1;
        end
      end
      if (found) begin
        tbl_used[best] = 1'b1;
        free_total -= tbl_size[best];
        r.leftover = tbl_size[best] - item.size;
        frag_total += r.leftover;
        if (frag_total > Sat32) frag_total = Sat32;
        r.block_index = IdxW'(best);
        r.status = bfa_pkg::StatAlloc;
      end else begin
        wait_total += item.size;
        if (wait_total > Sat32) wait_total = Sat32;
        r.status = bfa_pkg::StatWait;
      end
    end
    r.total_internal_frag = frag_total[SumW-1:0];
    if (free_total < wait_total) r.external_frag = '0;
    else if (free_total - wait_total > Sat32) r.external_frag = '1;
    else r.external_frag = SumW'(free_total - wait_total);
    return r;
  endfunction

  // Sizes biased towards small values so that ties and exact fits are common
  function automatic logic [SizeBits-1:0] pick_block_size();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return SizeBits'($urandom_range(0, 15));
      4:       return SizeBits'($urandom_range(0, 255));
      default: return SizeBits'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [SizeBits-1:0] pick_request_size();
    logic [SizeBits-1:0] base;
    int                  cut;
    base = '0;
    if (tbl_count > 0) base = tbl_size[$urandom_range(0, tbl_count - 1)];
    case ($urandom_range(0, 7))
      0:    return '0;
      1:    return '1;
      2, 3: return base;
      4: begin
        cut = $urandom_range(0, 3);
        return (base > cut) ? base - SizeBits'(cut) : '0;
      end
      5:       return (base == '1) ? base : base + 1'b1;
      6:       return SizeBits'($urandom_range(0, 15));
      default: return SizeBits'($urandom_range(0, 65535));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [1:0] op, input logic [SizeBits-1:0] sz);
    bfa_pkg::req_t item;
    item.operation = op;
    item.size      = sz;
    // each offered cycle is left idle with a 29% chance
    while (gaps_on && $urandom_range(0, 99) < 29) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= item;
    do begin
      @(posedge clk_i);
    end while (busy_o);
    pending_results.push_back(next_alloc_result(item));
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: status %0d", res_o.status);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, res_o.status);
        check_field("block_index", want.block_index, res_o.block_index);
        check_field("leftover", want.leftover, res_o.leftover);
        check_field("total_internal_frag", want.total_internal_frag,
                    res_o.total_internal_frag);
        check_field("external_frag", want.external_frag, res_o.external_frag);
        if (int'(want.status) < 5) n_status[int'(want.status)]++;
      end
    end
  end

  task automatic test_add_and_alloc();
    send_item(bfa_pkg::OpAlloc, '0);           // empty table: waits
    send_item(bfa_pkg::OpAdd, 16'hFFFF);
    send_item(bfa_pkg::OpAdd, 16'h0000);
    send_item(bfa_pkg::OpAdd, 16'd100);
    send_item(bfa_pkg::OpAdd, 16'd100);
    send_item(bfa_pkg::OpAdd, 16'hAAAA);
    send_item(bfa_pkg::OpAdd, 16'h5555);
    send_item(bfa_pkg::OpAlloc, 16'd100);      // tie, lower index wins
    send_item(bfa_pkg::OpAlloc, 16'd100);
    send_item(bfa_pkg::OpAlloc, 16'h0000);     // zero request takes the zero block
    send_item(bfa_pkg::OpAlloc, 16'hFFFF);     // exact fit on the largest
    send_item(bfa_pkg::OpAlloc, 16'hFFFF);
    send_item(bfa_pkg::OpAlloc, 16'd1);
    send_item(bfa_pkg::OpAlloc, 16'd50000);
  endtask

  task automatic test_clear_codes();
    send_item(bfa_pkg::OpAdd, 16'd7);
    send_item(bfa_pkg::OpClear, 16'h1234);
    send_item(bfa_pkg::OpAdd, 16'd3);
    send_item(OpSpare, 16'hFFFF);
    send_item(bfa_pkg::OpAlloc, 16'd3);
  endtask

  task automatic test_table_full();
    send_item(bfa_pkg::OpClear, '0);
    repeat (MaxBlocks) send_item(bfa_pkg::OpAdd, SizeBits'($urandom_range(0, 31)));
    send_item(bfa_pkg::OpAdd, 16'hFFFF);
    send_item(bfa_pkg::OpAlloc, 16'd5);
    send_item(bfa_pkg::OpAdd, 16'h0001);       // an allocated entry does not free a table slot
    send_item(bfa_pkg::OpClear, '0);
  endtask

  task automatic test_waiting_sum();
    gaps_on = 1'b0;
    send_item(bfa_pkg::OpClear, '0);
    send_item(bfa_pkg::OpAdd, 16'd10);
    // waiting sum overtakes the free sum, external fragmentation clamps at zero
    repeat (3) send_item(bfa_pkg::OpAlloc, 16'hFFFF);
    send_item(bfa_pkg::OpAlloc, 16'd5);
    send_item(bfa_pkg::OpClear, '0);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic(input int target);
    int first;
    int n_add;
    int n_req;
    first   = n_items;
    gaps_on = 1'b0;
    while (n_items - first < target) begin
      if (n_items - first > 300) gaps_on = 1'b1;
      send_item(($urandom_range(0, 9) == 0) ? OpSpare : bfa_pkg::OpClear,
                SizeBits'($urandom_range(0, 65535)));
      n_add = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 12);
      repeat (n_add) begin
        send_item(bfa_pkg::OpAdd, pick_block_size());
        if ($urandom_range(0, 99) < 30) send_item(bfa_pkg::OpAlloc, pick_request_size());
      end
      n_req = $urandom_range(1, 20);
      repeat (n_req) begin
        if ($urandom_range(0, 99) < 90) send_item(bfa_pkg::OpAlloc, pick_request_size());
        else send_item(bfa_pkg::OpAdd, pick_block_size());  // occasional stray add
      end
    end
  endtask

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("best_fit_block_allocator regression: fail");
    $finish;
  end

  initial begin
    rst_ni   = 1'b0;
    start_i  = 1'b0;
    req_i    = '0;
    n_items  = 0;
    n_errors = 0;
    gaps_on  = 1'b1;
    for (int i = 0; i < 5; i++) n_status[i] = 0;
    clear_table();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_add_and_alloc();
    test_clear_codes();
    test_table_full();
    test_waiting_sum();
    test_random_traffic(1240);

    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d items sent: %0d added, %0d full, %0d allocated, %0d waiting, %0d cleared",
             n_items, n_status[0], n_status[1], n_status[2], n_status[3], n_status[4]);
    $display("covered ties, exact and zero fits, spare opcode clear, full table, waiting requests");
    if (n_errors == 0) begin
      $display("best_fit_block_allocator regression: pass");
    end else begin
      $display("best_fit_block_allocator regression: fail");
    end
    $finish;
  end

endmodule
